[rtl/kissrx_pkg.sv]
package kissrx_pkg;

	localparam int MAX_FRAME_LEN_DEF = 512;

	localparam logic [7:0] BYTE_FEND  = 8'hC0;
	localparam logic [7:0] BYTE_FESC  = 8'hDB;
	localparam logic [7:0] BYTE_TFEND = 8'hDC;
	localparam logic [7:0] BYTE_TFESC = 8'hDD;
	localparam logic [7:0] TYPE_CRC   = 8'h20;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_GOOD = 16'h7070;

	// Frames with this many stored bytes or fewer are rejected as too short.
	localparam int SHORT_MAX = 14;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_TYPE = 4'b0010,
		PH_DATA = 4'b0100,
		PH_ESC  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CRC   = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		logic          emit;
		kind_t         kind;
		logic [7:0]    payload_byte;
		logic [8:0]    byte_position;
		status_t       frame_status;
		logic [9:0]    frame_length;
		logic          crc_active;
		logic          carrier_detect;
	} res_t;

	typedef logic [15:0] crc_tab_t [256];

	function automatic logic [15:0] crc_entry(input logic [7:0] idx);
		logic [15:0] acc;
		logic [7:0]  d;
		acc = CRC_INIT;
		d   = idx;
		for (int j = 0; j < 8; j++) begin
			if ((d[0] ^ acc[0]) == 1'b1) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
			d = d >> 1;
		end
		return acc;
	endfunction

	function automatic crc_tab_t crc_build();
		crc_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = crc_entry(8'(i));
		end
		return t;
	endfunction

	localparam crc_tab_t CRC_TABLE = crc_build();

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		return {crc[7:0], 8'h00} ^ CRC_TABLE[crc[15:8] ^ b];
	endfunction

endpackage

[rtl/kiss_rx_deframer_crc16.sv]
// KISS receive deframer with a 16-bit frame check.
// Input channel: in_valid / in_stall with rx_byte, one raw serial byte per
// item. Output channel: out_valid / out_stall with one result item per
// payload byte (result_kind 0) and one per closing FEND (result_kind 1,
// carrying frame_status and frame_length). Bytes that produce no result
// (FENDs while hunting, type bytes, escapes, dropped bytes) are consumed
// without an output item.
// A byte accepted into the input register passes the parse logic into the
// result register. Throughput is one item per cycle when the output is not
// stalled; the CRC update is one 256-entry table lookup and an XOR per byte,
// done in the same cycle as the parse state update.
// cfg_wr_en / cfg_wr_data set the CRC-check mode; write it only while no
// item is in flight.
// Reset puts the parser into hunting for a frame start, clears the CRC mode,
// the count and the carrier flag, and empties both registers.
// When the receiver stalls, the result is held and the input register fills;
// in_stall then rises until the result is taken.
module kiss_rx_deframer_crc16 #(
	parameter int MAX_FRAME_LEN = kissrx_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [7:0] payload_byte,
	output logic [8:0] byte_position,
	output logic [1:0] frame_status,
	output logic [9:0] frame_length,
	output logic       crc_active,
	output logic       carrier_detect
);

	import kissrx_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	res_t       res;
	res_t       res_q;

	// The held byte moves on whenever the result register is free or drains.
	assign advance = valid_s1 && (!out_valid || !out_stall);

	kissrx_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	kissrx_parser #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.byte_s1     (byte_s1),
		.res         (res)
	);

	kissrx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign result_kind    = res_q.kind;
	assign payload_byte   = res_q.payload_byte;
	assign byte_position  = res_q.byte_position;
	assign frame_status   = res_q.frame_status;
	assign frame_length   = res_q.frame_length;
	assign crc_active     = res_q.crc_active;
	assign carrier_detect = res_q.carrier_detect;

	a_kind_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (carrier_detect == (result_kind == KIND_BYTE)))
		else $error("carrier_detect does not match result kind");

endmodule

[rtl/kissrx_in_reg.sv]
module kissrx_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic valid_q;
	logic load;

	// The held item leaves whenever the parser advances, so a new item can
	// enter in the same cycle.
	assign in_stall = valid_q && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

	assign valid_s1 = valid_q;

endmodule

[rtl/kissrx_parser.sv]
module kissrx_parser #(
	parameter int MAX_FRAME_LEN = kissrx_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              advance,
	input  logic [7:0]        byte_s1,
	output kissrx_pkg::res_t  res
);

	import kissrx_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

	phase_t            phase_q, phase_d;
	logic [15:0]       crc_q, crc_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              sticky_q, sticky_d;
	logic              carrier_q, carrier_d;
	logic              crc_enable_q;

	logic              active;
	logic              fold;
	logic [7:0]        fold_byte;
	logic              room;
	logic [CNT_W-1:0]  len;

	assign active   = crc_enable_q | sticky_q;
	assign room     = count_q < CNT_W'(MAX_FRAME_LEN);
	assign len      = count_q - (active ? CNT_W'(2) : CNT_W'(0));

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		count_d   = count_q;
		sticky_d  = sticky_q;
		carrier_d = carrier_q;
		fold      = 1'b0;
		fold_byte = byte_s1;

		res                = '0;
		res.kind           = KIND_BYTE;
		res.frame_status   = ST_OK;
		res.crc_active     = active;

		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == BYTE_FEND) begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (byte_s1 != BYTE_FEND) begin
					if (byte_s1[3:0] != 4'h0) begin
						// Command frame: skip it entirely.
						phase_d   = PH_HUNT;
						carrier_d = 1'b0;
					end else begin
						if (byte_s1 == TYPE_CRC) begin
							sticky_d = 1'b1;
						end
						fold      = 1'b1;
						phase_d   = PH_DATA;
						carrier_d = 1'b1;
					end
				end
			end
			PH_DATA: begin
				if (byte_s1 == BYTE_FEND) begin
					res.emit = 1'b1;
					res.kind = KIND_END;
					if (count_q > CNT_W'(SHORT_MAX)) begin
						if (!active || crc_q == CRC_GOOD) begin
							res.frame_status = ST_OK;
							res.frame_length = 10'(len);
						end else begin
							res.frame_status = ST_CRC;
						end
					end else begin
						res.frame_status = ST_SHORT;
					end
					count_d   = '0;
					crc_d     = CRC_INIT;
					carrier_d = 1'b0;
					phase_d   = PH_TYPE;
				end else if (byte_s1 == BYTE_FESC) begin
					phase_d = PH_ESC;
				end else if (room) begin
					fold = 1'b1;
				end
			end
			PH_ESC: begin
				phase_d = PH_DATA;
				if (byte_s1 == BYTE_TFEND) begin
					fold_byte = BYTE_FEND;
					fold      = room;
				end else if (byte_s1 == BYTE_TFESC) begin
					fold_byte = BYTE_FESC;
					fold      = room;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase

		if (fold) begin
			crc_d = crc_fold(crc_q, fold_byte);
		end

		// Payload bytes count and produce a result; the type byte only folds.
		if (fold && phase_q != PH_TYPE) begin
			res.emit           = 1'b1;
			res.kind           = KIND_BYTE;
			res.payload_byte   = fold_byte;
			res.byte_position  = 9'(count_q);
			res.carrier_detect = carrier_q;
			count_d            = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			crc_q        <= CRC_INIT;
			count_q      <= '0;
			sticky_q     <= 1'b0;
			carrier_q    <= 1'b0;
			crc_enable_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				crc_enable_q <= cfg_wr_data;
			end
			if (advance) begin
				phase_q   <= phase_d;
				crc_q     <= crc_d;
				count_q   <= count_d;
				sticky_q  <= sticky_d;
				carrier_q <= carrier_d;
			end
		end
	end

	a_carrier_phase: assert property (@(posedge clk) disable iff (!arst_n)
		carrier_q == (phase_q == PH_DATA || phase_q == PH_ESC))
		else $error("carrier flag disagrees with parse phase");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT || phase_q == PH_TYPE) |-> (count_q == '0 && crc_q == CRC_INIT))
		else $error("count or CRC not cleared between frames");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_LEN))
		else $error("byte count beyond frame limit");

endmodule

[rtl/kissrx_out_reg.sv]
module kissrx_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  kissrx_pkg::res_t  res,
	input  logic              out_stall,
	output logic              out_valid,
	output kissrx_pkg::res_t  res_q
);

	import kissrx_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.emit;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule
